// ----- src/cfds_pkg.sv -----
package cfds_pkg;

    localparam int SAMPLE_W = 32;
    localparam int GAIN_W   = 31;
    localparam int DF_W     = 6;
    localparam int IDX_W    = 3;

    localparam logic [IDX_W-1:0] REG_DIRECT_GAIN  = 3'd0;
    localparam logic [IDX_W-1:0] REG_COEF_B0      = 3'd1;
    localparam logic [IDX_W-1:0] REG_COEF_B1      = 3'd2;
    localparam logic [IDX_W-1:0] REG_COEF_A1      = 3'd3;
    localparam logic [IDX_W-1:0] REG_DELAY_FRAMES = 3'd4;

    localparam logic [GAIN_W-1:0] DIRECT_GAIN_RST  = 31'h7fff_ffff;
    localparam logic [DF_W-1:0]   DELAY_FRAMES_RST = 6'd13;

    // s0.31 multiply: bits 62..31 of the exact signed product
    function automatic logic [SAMPLE_W-1:0] frac_mul(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b
    );
        logic signed [2*SAMPLE_W-1:0] p;
        p = a * b;
        return p[2*SAMPLE_W-2:SAMPLE_W-1];
    endfunction

endpackage

// ----- src/crossfeed_delay_shelf_filter.sv -----
// Headphone crossfeed: one stereo frame in, one crossfed frame out, one frame per
// clock when the output is not stalled; an accepted input beat passes the s1, s2,
// s3 and output registers. Both delay lines share one RAM that is read and written
// at the same position for each frame; per-entry valid bits make the store read as
// zero after reset, so no clearing pass is needed. The rate is set by the feedback
// loop of each shelf filter, which multiplies the previous output by coef_a1 and
// adds it combinationally ahead of the yl/yr registers. Stages that hold bubbles
// keep taking frames while a finished result waits. The user writes registers over
// APB only while no frame is in flight; the block itself does not enforce this.
module crossfeed_delay_shelf_filter
    import cfds_pkg::*;
#(
    parameter int MAX_DELAY_FRAMES = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [4:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       frame_valid,
    output logic                       frame_stall,
    input  logic signed [SAMPLE_W-1:0] left_in,
    input  logic signed [SAMPLE_W-1:0] right_in,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic signed [SAMPLE_W-1:0] left_out,
    output logic signed [SAMPLE_W-1:0] right_out
);

    logic [GAIN_W-1:0]          direct_gain_reg;
    logic signed [SAMPLE_W-1:0] coef_b0_reg;
    logic signed [SAMPLE_W-1:0] coef_b1_reg;
    logic signed [SAMPLE_W-1:0] coef_a1_reg;
    logic [DF_W-1:0]            delay_frames_reg;
    logic                       cfg_wr;
    logic [IDX_W-1:0]           cfg_idx;

    logic                s1_valid_reg;
    logic [SAMPLE_W-1:0] s1_left_reg;
    logic [SAMPLE_W-1:0] s1_right_reg;
    logic [SAMPLE_W-1:0] xprev_l_reg;
    logic [SAMPLE_W-1:0] xprev_r_reg;
    logic                s2_valid_reg;
    logic [SAMPLE_W-1:0] s2_pl_reg;
    logic [SAMPLE_W-1:0] s2_pr_reg;
    logic [SAMPLE_W-1:0] s2_gl_reg;
    logic [SAMPLE_W-1:0] s2_gr_reg;
    logic                s3_valid_reg;
    logic [SAMPLE_W-1:0] yl_reg;
    logic [SAMPLE_W-1:0] yr_reg;
    logic [SAMPLE_W-1:0] s3_gl_reg;
    logic [SAMPLE_W-1:0] s3_gr_reg;
    logic                result_valid_reg;
    logic [SAMPLE_W-1:0] left_out_reg;
    logic [SAMPLE_W-1:0] right_out_reg;

    logic                en_out;
    logic                en3;
    logic                en2;
    logic                en1;
    logic                accept;
    logic                mv2;
    logic                mv3;
    logic                mv_out;
    logic [SAMPLE_W-1:0] dl_l;
    logic [SAMPLE_W-1:0] dl_r;
    logic [SAMPLE_W-1:0] pl_next;
    logic [SAMPLE_W-1:0] pr_next;
    logic [SAMPLE_W-1:0] gl_next;
    logic [SAMPLE_W-1:0] gr_next;
    logic [SAMPLE_W-1:0] yl_next;
    logic [SAMPLE_W-1:0] yr_next;
    logic signed [SAMPLE_W-1:0] gain_s;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_comb
    begin
        unique case (cfg_idx)
            REG_DIRECT_GAIN:  prdata = {1'b0, direct_gain_reg};
            REG_COEF_B0:      prdata = coef_b0_reg;
            REG_COEF_B1:      prdata = coef_b1_reg;
            REG_COEF_A1:      prdata = coef_a1_reg;
            REG_DELAY_FRAMES: prdata = {26'd0, delay_frames_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direct_gain_reg  <= DIRECT_GAIN_RST;
            coef_b0_reg      <= '0;
            coef_b1_reg      <= '0;
            coef_a1_reg      <= '0;
            delay_frames_reg <= DELAY_FRAMES_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_DIRECT_GAIN:  direct_gain_reg  <= pwdata[GAIN_W-1:0];
                REG_COEF_B0:      coef_b0_reg      <= pwdata;
                REG_COEF_B1:      coef_b1_reg      <= pwdata;
                REG_COEF_A1:      coef_a1_reg      <= pwdata;
                REG_DELAY_FRAMES: delay_frames_reg <= pwdata[DF_W-1:0];
                default:          ;
            endcase
        end
    end

    assign en_out      = !result_valid_reg || !result_stall;
    assign en3         = !s3_valid_reg || en_out;
    assign en2         = !s2_valid_reg || en3;
    assign en1         = !s1_valid_reg || en2;
    assign frame_stall = !en1;
    assign accept      = frame_valid && en1;
    assign mv2         = s1_valid_reg && en2;
    assign mv3         = s2_valid_reg && en3;
    assign mv_out      = s3_valid_reg && en_out;

    cfds_delay #(
        .MAX_DELAY_FRAMES(MAX_DELAY_FRAMES)
    ) u_delay (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (accept),
        .left_wr      (left_in),
        .right_wr     (right_in),
        .delay_frames (delay_frames_reg),
        .left_rd      (dl_l),
        .right_rd     (dl_r)
    );

    assign gain_s  = signed'({1'b0, direct_gain_reg});
    assign pl_next = frac_mul(dl_l, coef_b0_reg) + frac_mul(xprev_l_reg, coef_b1_reg);
    assign pr_next = frac_mul(dl_r, coef_b0_reg) + frac_mul(xprev_r_reg, coef_b1_reg);
    assign gl_next = frac_mul(s1_left_reg, gain_s);
    assign gr_next = frac_mul(s1_right_reg, gain_s);
    assign yl_next = s2_pl_reg + frac_mul(yl_reg, coef_a1_reg);
    assign yr_next = s2_pr_reg + frac_mul(yr_reg, coef_a1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            xprev_l_reg      <= '0;
            xprev_r_reg      <= '0;
            yl_reg           <= '0;
            yr_reg           <= '0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= frame_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en_out)
            begin
                result_valid_reg <= s3_valid_reg;
            end
            if (mv2)
            begin
                xprev_l_reg <= dl_l;
                xprev_r_reg <= dl_r;
            end
            if (mv3)
            begin
                yl_reg <= yl_next;
                yr_reg <= yr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_left_reg  <= left_in;
            s1_right_reg <= right_in;
        end
        if (mv2)
        begin
            s2_pl_reg <= pl_next;
            s2_pr_reg <= pr_next;
            s2_gl_reg <= gl_next;
            s2_gr_reg <= gr_next;
        end
        if (mv3)
        begin
            s3_gl_reg <= s2_gl_reg;
            s3_gr_reg <= s2_gr_reg;
        end
        if (mv_out)
        begin
            left_out_reg  <= s3_gl_reg + yr_reg;
            right_out_reg <= s3_gr_reg + yl_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign left_out     = left_out_reg;
    assign right_out    = right_out_reg;

endmodule

// ----- src/cfds_delay.sv -----
module cfds_delay
    import cfds_pkg::*;
#(
    parameter int MAX_DELAY_FRAMES = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [SAMPLE_W-1:0] left_wr,
    input  logic [SAMPLE_W-1:0] right_wr,
    input  logic [DF_W-1:0]     delay_frames,
    output logic [SAMPLE_W-1:0] left_rd,
    output logic [SAMPLE_W-1:0] right_rd
);

    localparam int AW = (MAX_DELAY_FRAMES > 1) ? $clog2(MAX_DELAY_FRAMES) : 1;
    localparam int LW = $clog2(MAX_DELAY_FRAMES + 1);
    localparam int CW = (LW + 1 > DF_W) ? LW + 1 : DF_W;

    logic [2*SAMPLE_W-1:0] mem [MAX_DELAY_FRAMES];
    logic [2*SAMPLE_W-1:0] rd_data_reg;
    logic                  rd_vld_reg;
    logic [MAX_DELAY_FRAMES-1:0] vld_reg;
    logic [AW-1:0]         pos_reg;
    logic [AW-1:0]         pos_next;
    logic [CW-1:0]         df_ext;
    logic [CW-1:0]         len;
    logic [CW-1:0]         pos_inc;

    always_comb
    begin
        df_ext = CW'(delay_frames);
        if (df_ext == '0)
        begin
            len = CW'(1);
        end
        else if (df_ext > CW'(MAX_DELAY_FRAMES))
        begin
            len = CW'(MAX_DELAY_FRAMES);
        end
        else
        begin
            len = df_ext;
        end
        pos_inc  = CW'(pos_reg) + CW'(1);
        pos_next = (pos_inc >= len) ? '0 : pos_inc[AW-1:0];
    end

    // read-first: the old sample leaves as the new one is stored
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rd_data_reg  <= mem[pos_reg];
            mem[pos_reg] <= {left_wr, right_wr};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
            pos_reg    <= '0;
        end
        else if (wr_en)
        begin
            rd_vld_reg       <= vld_reg[pos_reg];
            vld_reg[pos_reg] <= 1'b1;
            pos_reg          <= pos_next;
        end
    end

    assign left_rd  = rd_vld_reg ? rd_data_reg[2*SAMPLE_W-1:SAMPLE_W] : '0;
    assign right_rd = rd_vld_reg ? rd_data_reg[SAMPLE_W-1:0] : '0;

endmodule

// ----- src/cfds_checker.sv -----
module cfds_checker
    import cfds_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                frame_valid,
    input logic                frame_stall,
    input logic                result_valid,
    input logic                result_stall,
    input logic [SAMPLE_W-1:0] left_out,
    input logic [SAMPLE_W-1:0] right_out
);

    logic [2:0] inflight_reg;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = frame_valid && !frame_stall;
    assign out_beat = result_valid && !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else if (in_beat && !out_beat)
        begin
            inflight_reg <= inflight_reg + 3'd1;
        end
        else if (out_beat && !in_beat)
        begin
            inflight_reg <= inflight_reg - 3'd1;
        end
    end

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(left_out) && $stable(right_out))
        else $error("stalled result beat changed");

    // input stalls only when the whole pipe is full behind a blocked result
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        frame_stall |-> result_valid && result_stall && inflight_reg == 3'd4)
        else $error("input stalled with room in the pipe");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> inflight_reg != 3'd0)
        else $error("result beat without an accepted frame");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 3'd4)
        else $error("more frames in flight than pipe stages");

endmodule

bind crossfeed_delay_shelf_filter cfds_checker u_cfds_checker (.*);
